// ----- design/fvn_pkg.sv -----
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared constants, payload types and the permutation table for the fractal
// value noise unit.
// ----------------------------------------------------------------------------
`default_nettype none
package fvn_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int MAX_OCTAVES = 8;
  localparam int INT_BITS    = 8;
  localparam int POS_W       = INT_BITS + FRAC_BITS;
  localparam int COORD_W     = 24;
  localparam int FREQ_W      = 16;
  localparam int FREQ_FRAC   = 8;
  localparam int SEED_W      = 8;
  localparam int OCT_W       = 4;
  localparam int K_W         = $clog2(MAX_OCTAVES + 1);
  localparam int VAL_W       = FRAC_BITS + INT_BITS;
  localparam int ACC_W       = VAL_W + MAX_OCTAVES;
  localparam int DIV_W       = ACC_W - INT_BITS;
  localparam int NOISE_W     = 16;
  localparam int DEN_W       = MAX_OCTAVES;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_OCT  = 2'd1;
  localparam logic [1:0] REG_FREQ = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [ACC_W-1:0] acc;
  } fvn_item_t;

  localparam logic [7:0] PERM_ROM [256] = '{
    8'd208,8'd34,8'd231,8'd213,8'd32,8'd248,8'd233,8'd56,8'd161,8'd78,8'd24,8'd140,
    8'd71,8'd48,8'd140,8'd254,8'd245,8'd255,8'd247,8'd247,8'd40,8'd185,8'd248,8'd251,
    8'd245,8'd28,8'd124,8'd204,8'd204,8'd76,8'd36,8'd1,8'd107,8'd28,8'd234,8'd163,
    8'd202,8'd224,8'd245,8'd128,8'd167,8'd204,8'd9,8'd92,8'd217,8'd54,8'd239,8'd174,
    8'd173,8'd102,8'd193,8'd189,8'd190,8'd121,8'd100,8'd108,8'd167,8'd44,8'd43,8'd77,
    8'd180,8'd204,8'd8,8'd81,8'd70,8'd223,8'd11,8'd38,8'd24,8'd254,8'd210,8'd210,
    8'd177,8'd32,8'd81,8'd195,8'd243,8'd125,8'd8,8'd169,8'd112,8'd32,8'd97,8'd53,
    8'd195,8'd13,8'd203,8'd9,8'd47,8'd104,8'd125,8'd117,8'd114,8'd124,8'd165,8'd203,
    8'd181,8'd235,8'd193,8'd206,8'd70,8'd180,8'd174,8'd0,8'd167,8'd181,8'd41,8'd164,
    8'd30,8'd116,8'd127,8'd198,8'd245,8'd146,8'd87,8'd224,8'd149,8'd206,8'd57,8'd4,
    8'd192,8'd210,8'd65,8'd210,8'd129,8'd240,8'd178,8'd105,8'd228,8'd108,8'd245,8'd148,
    8'd140,8'd40,8'd35,8'd195,8'd38,8'd58,8'd65,8'd207,8'd215,8'd253,8'd65,8'd85,
    8'd208,8'd76,8'd62,8'd3,8'd237,8'd55,8'd89,8'd232,8'd50,8'd217,8'd64,8'd244,
    8'd157,8'd199,8'd121,8'd252,8'd90,8'd17,8'd212,8'd203,8'd149,8'd152,8'd140,8'd187,
    8'd234,8'd177,8'd73,8'd174,8'd193,8'd100,8'd192,8'd143,8'd97,8'd53,8'd145,8'd135,
    8'd19,8'd103,8'd13,8'd90,8'd135,8'd151,8'd199,8'd91,8'd239,8'd247,8'd33,8'd39,
    8'd145,8'd101,8'd120,8'd99,8'd3,8'd186,8'd86,8'd99,8'd41,8'd237,8'd203,8'd111,
    8'd79,8'd220,8'd135,8'd158,8'd42,8'd30,8'd154,8'd120,8'd67,8'd87,8'd167,8'd135,
    8'd176,8'd183,8'd191,8'd253,8'd115,8'd184,8'd21,8'd233,8'd58,8'd129,8'd233,8'd142,
    8'd39,8'd128,8'd211,8'd118,8'd137,8'd139,8'd255,8'd114,8'd20,8'd218,8'd113,8'd154,
    8'd27,8'd127,8'd246,8'd250,8'd1,8'd8,8'd198,8'd250,8'd209,8'd92,8'd222,8'd173,
    8'd21,8'd88,8'd102,8'd219
  };

  function automatic logic [7:0] perm_lookup(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

endpackage
`default_nettype wire

// ----- design/fvn_octave_cell.sv -----
// ----------------------------------------------------------------------------
// fvn_octave_cell
// One octave of value noise: lattice hash, smoothstep, bilinear blend and
// Horner accumulation, five register stages. Hands a doubled position on.
// ----------------------------------------------------------------------------
`default_nettype none
module fvn_octave_cell
  import fvn_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [SEED_W-1:0] seed_i,
  input  wire logic [K_W-1:0]   k_i,
  input  wire logic [K_W-1:0]   oct_idx_i,
  input  wire logic             valid_i,
  input  wire fvn_item_t        item_i,
  output logic                  valid_o,
  output fvn_item_t             item_o
);

  localparam logic [FRAC_BITS+1:0] THREE_FX = (FRAC_BITS+2)'(3) << FRAC_BITS;
  localparam logic [FRAC_BITS:0]   ONE_FX   = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [3:0]            valid_q;
  fvn_item_t             item1_q, item2_q, item3_q, item4_q;

  // stage 1 registers
  logic [INT_BITS-1:0]   ix1_q;
  logic [FRAC_BITS-1:0]  fx1_q, fy1_q, f2x1_q, f2y1_q;
  logic [7:0]            row0_q, row1_q;
  // stage 2 registers
  logic [FRAC_BITS-1:0]  wx2_q, wy2_q;
  logic [7:0]            c00_q, c10_q, c01_q, c11_q;
  // stage 3 registers
  logic [FRAC_BITS-1:0]  wy3_q;
  logic [VAL_W-1:0]      lo_q, hi_q;
  // stage 4 registers
  logic [VAL_W-1:0]      v_q;

  logic [INT_BITS-1:0]   ix0, iy0;
  logic [FRAC_BITS-1:0]  fx0, fy0;
  logic [2*FRAC_BITS-1:0] sqx, sqy;
  logic [FRAC_BITS+1:0]  tx, ty;
  logic [2*FRAC_BITS+1:0] wpx, wpy;
  logic [FRAC_BITS:0]    owx, owy;
  logic [VAL_W:0]        lo_d, hi_d;
  logic [VAL_W+FRAC_BITS+1:0] blend;
  logic                  active;

  always_comb begin
    ix0  = item_i.px[POS_W-1:FRAC_BITS];
    iy0  = item_i.py[POS_W-1:FRAC_BITS];
    fx0  = item_i.px[FRAC_BITS-1:0];
    fy0  = item_i.py[FRAC_BITS-1:0];
    sqx  = fx0 * fx0;
    sqy  = fy0 * fy0;
    tx   = THREE_FX - {1'b0, fx1_q, 1'b0};
    ty   = THREE_FX - {1'b0, fy1_q, 1'b0};
    wpx  = f2x1_q * tx;
    wpy  = f2y1_q * ty;
    owx  = ONE_FX - {1'b0, wx2_q};
    lo_d = c00_q * owx + c10_q * wx2_q;
    hi_d = c01_q * owx + c11_q * wx2_q;
    owy  = ONE_FX - {1'b0, wy3_q};
    blend = lo_q * owy + hi_q * wy3_q;
    active = (oct_idx_i < k_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
      valid_o <= valid_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: fraction squares, row hashes
      item1_q <= item_i;
      ix1_q   <= ix0;
      fx1_q   <= fx0;
      fy1_q   <= fy0;
      f2x1_q  <= sqx[2*FRAC_BITS-1:FRAC_BITS];
      f2y1_q  <= sqy[2*FRAC_BITS-1:FRAC_BITS];
      row0_q  <= perm_lookup(iy0 + seed_i);
      row1_q  <= perm_lookup(iy0 + 8'd1 + seed_i);
      // stage 2: smoothstep weights, corner hashes
      item2_q <= item1_q;
      wx2_q   <= wpx[2*FRAC_BITS-1:FRAC_BITS];
      wy2_q   <= wpy[2*FRAC_BITS-1:FRAC_BITS];
      c00_q   <= perm_lookup(row0_q + ix1_q);
      c10_q   <= perm_lookup(row0_q + ix1_q + 8'd1);
      c01_q   <= perm_lookup(row1_q + ix1_q);
      c11_q   <= perm_lookup(row1_q + ix1_q + 8'd1);
      // stage 3: row blends
      item3_q <= item2_q;
      wy3_q   <= wy2_q;
      lo_q    <= lo_d[VAL_W-1:0];
      hi_q    <= hi_d[VAL_W-1:0];
      // stage 4: column blend
      item4_q <= item3_q;
      v_q     <= blend[VAL_W+FRAC_BITS-1:FRAC_BITS];
      // stage 5: accumulate, double position for the next octave
      item_o.px  <= {item4_q.px[POS_W-2:0], 1'b0};
      item_o.py  <= {item4_q.py[POS_W-2:0], 1'b0};
      item_o.acc <= active ? ({item4_q.acc[ACC_W-2:0], 1'b0} + ACC_W'(v_q))
                           : item4_q.acc;
    end
  end

endmodule
`default_nettype wire

// ----- design/fvn_divider.sv -----
// ----------------------------------------------------------------------------
// fvn_divider
// Restoring divider, one quotient bit per stage, for the normalization by
// the total octave weight.
// ----------------------------------------------------------------------------
`default_nettype none
module fvn_divider
  import fvn_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic             valid_i,
  input  wire logic [DIV_W-1:0] num_i,
  output logic                  valid_o,
  output logic [NOISE_W-1:0]    quot_o
);

  logic [NOISE_W-1:0] valid_q;
  logic [DIV_W-1:0]   rem_q   [NOISE_W];
  logic [NOISE_W-1:0] quot_q  [NOISE_W];
  logic [DIV_W-1:0]   rem_in  [NOISE_W];
  logic [NOISE_W-1:0] quot_in [NOISE_W];
  logic [DIV_W-1:0]   rem_d   [NOISE_W];
  logic [NOISE_W-1:0] quot_d  [NOISE_W];
  logic [DIV_W-1:0]   trial;

  // Stage g decides quotient bit NOISE_W-1-g
  always_comb begin
    rem_in[0]  = num_i;
    quot_in[0] = '0;
    for (int g = 1; g < NOISE_W; g++) begin
      rem_in[g]  = rem_q[g-1];
      quot_in[g] = quot_q[g-1];
    end
    for (int g = 0; g < NOISE_W; g++) begin
      trial     = DIV_W'(den_i) << (NOISE_W - 1 - g);
      rem_d[g]  = rem_in[g];
      quot_d[g] = quot_in[g];
      if (rem_in[g] >= trial) begin
        rem_d[g] = rem_in[g] - trial;
        quot_d[g][NOISE_W-1-g] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[NOISE_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < NOISE_W; g++) begin
        rem_q[g]  <= rem_d[g];
        quot_q[g] <= quot_d[g];
      end
    end
  end

  assign valid_o = valid_q[NOISE_W-1];
  assign quot_o  = quot_q[NOISE_W-1];

endmodule
`default_nettype wire

// ----- design/fractal_value_noise_2d_unit.sv -----
// ----------------------------------------------------------------------------
// fractal_value_noise_2d_unit
// Pipeline: 1 scaling stage, 5 stages in each of the 8 octave cells,
// 16 divider stages and an output register.
// Throughput: one transaction per cycle; the whole pipeline holds only while
// a result waits in the output register and m_axis_tready is low.
// Reset: asynchronous, clears the pipeline valids and loads seed 0,
// octaves 7, base_frequency 256.
// ----------------------------------------------------------------------------
`default_nettype none
module fractal_value_noise_2d_unit
  import fvn_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // coord_x [23:0], coord_y [47:24]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // noise_value [15:0]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [SEED_W-1:0] seed_q;
  logic [OCT_W-1:0]  oct_q;
  logic [FREQ_W-1:0] freq_q;
  logic [K_W-1:0]    k_eff;
  logic [DEN_W:0]    den_full;
  logic              en;

  logic              v0_q;
  fvn_item_t         item0_q;
  logic [COORD_W+FREQ_W-1:0] sx, sy;

  logic              cv   [MAX_OCTAVES+1];
  fvn_item_t         citem[MAX_OCTAVES+1];

  logic              div_v;
  logic [NOISE_W-1:0] div_q;

  assign pready = 1'b1;
  assign en     = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      oct_q  <= OCT_W'(7);
      freq_q <= FREQ_W'(256);
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_SEED: seed_q <= pwdata[SEED_W-1:0];
        REG_OCT:  oct_q  <= pwdata[OCT_W-1:0];
        REG_FREQ: freq_q <= pwdata[FREQ_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SEED: prdata = 32'(seed_q);
      REG_OCT:  prdata = 32'(oct_q);
      REG_FREQ: prdata = 32'(freq_q);
      default:  prdata = '0;
    endcase
  end

  // Saturate the octave count to 1..MAX_OCTAVES
  always_comb begin
    if (oct_q == '0) begin
      k_eff = K_W'(1);
    end else if (32'(oct_q) > MAX_OCTAVES) begin
      k_eff = K_W'(MAX_OCTAVES);
    end else begin
      k_eff = K_W'(oct_q);
    end
    den_full = ((DEN_W+1)'(1) << k_eff) - (DEN_W+1)'(1);
  end

  assign sx = s_axis_tdata[COORD_W-1:0] * freq_q;
  assign sy = s_axis_tdata[2*COORD_W-1:COORD_W] * freq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      item0_q.px  <= sx[FREQ_FRAC+POS_W-1:FREQ_FRAC];
      item0_q.py  <= sy[FREQ_FRAC+POS_W-1:FREQ_FRAC];
      item0_q.acc <= '0;
    end
  end

  assign cv[0]    = v0_q;
  assign citem[0] = item0_q;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    fvn_octave_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .seed_i    (seed_q),
      .k_i       (k_eff),
      .oct_idx_i (K_W'(i)),
      .valid_i   (cv[i]),
      .item_i    (citem[i]),
      .valid_o   (cv[i+1]),
      .item_o    (citem[i+1])
    );
  end

  fvn_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .den_i   (den_full[DEN_W-1:0]),
    .valid_i (cv[MAX_OCTAVES]),
    .num_i   (citem[MAX_OCTAVES].acc[ACC_W-1:INT_BITS]),
    .valid_o (div_v),
    .quot_o  (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= div_q;
    end
  end

endmodule
`default_nettype wire
